FILE: rtl/arp_rc_pkg.sv
// Shared types and constants for the ARP receive and cache block.
// Used by every module in rtl/ but arp_rc_ram; depends on nothing else.
`default_nettype none

package arp_rc_pkg;

  localparam int ENTRIES = 256;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OPC_REQUEST = 16'h0001;
  localparam logic [15:0] OPC_REPLY   = 16'h0002;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_ANSWERED = 3'd0,
    ST_LEARNED  = 3'd1,
    ST_OTHER    = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_NOT_US   = 3'd4,
    ST_HIT      = 3'd5,
    ST_MISS     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_LAST,
    ENG_COMMIT
  } eng_state_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [47:0] local_mac;
  } cfg_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic        op;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] arp_opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        merged;
    logic        table_full;
    logic        send_reply;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_dst_ip;
    logic [47:0] found_mac;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/arp_rc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Standalone; no package dependency.
`default_nettype none

module arp_rc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 80,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/arp_rc_cfg.sv
// APB-style register file holding the local IP and MAC addresses.
// Depends on arp_rc_pkg for cfg_t.
`default_nettype none

module arp_rc_cfg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  output arp_rc_pkg::cfg_t        cfg
);

  logic [31:0] local_ip_r;
  logic [47:0] local_mac_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Each register occupies an 8-byte slot; bit 3 selects the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r  <= '0;
      local_mac_r <= '0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        local_mac_r <= pwdata[47:0];
      end else begin
        local_ip_r <= pwdata[31:0];
      end
    end
  end

  always_comb begin
    if (paddr[3]) begin
      prdata = {16'h0000, local_mac_r};
    end else begin
      prdata = {32'h0000_0000, local_ip_r};
    end
  end

  assign cfg.local_ip  = local_ip_r;
  assign cfg.local_mac = local_mac_r;

endmodule

`default_nettype wire

FILE: rtl/arp_rc_engine.sv
// Scan engine: walks the entry table once per lookup or supported packet, then updates it and
// registers the result. Depends on arp_rc_pkg and arp_rc_ram.
`default_nettype none

module arp_rc_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire arp_rc_pkg::cfg_t    cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire arp_rc_pkg::item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output arp_rc_pkg::result_t      out_res
);

  localparam int AW = arp_rc_pkg::AW;

  arp_rc_pkg::eng_state_t state_r, state_nxt;

  logic [arp_rc_pkg::ENTRIES-1:0] valid_r;

  // Latched request.
  logic        op_r;
  logic        supported_r;
  logic [15:0] opc_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] tip_r;
  logic [31:0] key_r;

  // Scan bookkeeping.
  logic [AW-1:0] addr_r;
  logic [AW-1:0] cmp_addr_r;
  logic          cmp_vld_r;
  logic          found_r;
  logic [AW-1:0] match_slot_r;
  logic [47:0]   match_mac_r;
  logic          free_found_r;
  logic [AW-1:0] free_slot_r;

  logic                 out_valid_r;
  arp_rc_pkg::result_t  out_res_r;

  arp_rc_pkg::entry_t rd_data;
  arp_rc_pkg::entry_t wr_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;

  logic                accept;
  logic                commit;
  logic                cmp_hit;
  logic                cmp_free;
  logic                for_us;
  logic                merged;
  logic                insert;
  logic                full;
  arp_rc_pkg::result_t res;

  arp_rc_ram #(
    .DEPTH (arp_rc_pkg::ENTRIES),
    .WIDTH ($bits(arp_rc_pkg::entry_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == arp_rc_pkg::ENG_IDLE);
  assign accept   = in_valid & in_ready;
  assign rd_en    = (state_r == arp_rc_pkg::ENG_SCAN);

  // Compare stage sees the entry read in the previous cycle.
  assign cmp_hit  = cmp_vld_r & valid_r[cmp_addr_r] & (rd_data.ip == key_r);
  assign cmp_free = cmp_vld_r & ~valid_r[cmp_addr_r];

  assign for_us = (tip_r == cfg.local_ip);
  assign merged = (op_r == arp_rc_pkg::OP_PACKET) & supported_r & found_r;
  assign insert = (op_r == arp_rc_pkg::OP_PACKET) & supported_r & ~found_r & for_us
                  & free_found_r;
  assign full   = (op_r == arp_rc_pkg::OP_PACKET) & supported_r & ~found_r & for_us
                  & ~free_found_r;

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    case (state_r)
      arp_rc_pkg::ENG_IDLE: begin
        if (accept) begin
          if ((in_item.op == arp_rc_pkg::OP_PACKET) &&
              ((in_item.hw_type != arp_rc_pkg::HW_ETHERNET) ||
               (in_item.proto_type != arp_rc_pkg::PROTO_IPV4))) begin
            state_nxt = arp_rc_pkg::ENG_COMMIT;
          end else begin
            state_nxt = arp_rc_pkg::ENG_SCAN;
          end
        end
      end
      arp_rc_pkg::ENG_SCAN: begin
        if (addr_r == AW'(arp_rc_pkg::ENTRIES - 1)) begin
          state_nxt = arp_rc_pkg::ENG_LAST;
        end
      end
      arp_rc_pkg::ENG_LAST: begin
        state_nxt = arp_rc_pkg::ENG_COMMIT;
      end
      arp_rc_pkg::ENG_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = arp_rc_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = arp_rc_pkg::ENG_IDLE;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (op_r == arp_rc_pkg::OP_LOOKUP) begin
      if (found_r) begin
        res.status    = arp_rc_pkg::ST_HIT;
        res.found_mac = match_mac_r;
      end else begin
        res.status = arp_rc_pkg::ST_MISS;
      end
    end else if (!supported_r) begin
      res.status = arp_rc_pkg::ST_DROPPED;
    end else begin
      res.merged     = merged;
      res.table_full = full;
      if (!for_us) begin
        res.status = arp_rc_pkg::ST_NOT_US;
      end else if (opc_r == arp_rc_pkg::OPC_REQUEST) begin
        res.status        = arp_rc_pkg::ST_ANSWERED;
        res.send_reply    = 1'b1;
        res.reply_dst_mac = smac_r;
        res.reply_dst_ip  = sip_r;
      end else if (opc_r == arp_rc_pkg::OPC_REPLY) begin
        res.status = arp_rc_pkg::ST_LEARNED;
      end else begin
        res.status = arp_rc_pkg::ST_OTHER;
      end
    end
  end

  // A refresh rewrites the matched slot; the stored IP is already equal.
  assign wr_en       = commit & (merged | insert);
  assign wr_addr     = merged ? match_slot_r : free_slot_r;
  assign wr_data.ip  = sip_r;
  assign wr_data.mac = smac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arp_rc_pkg::ENG_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_en;
      if (commit && insert) begin
        valid_r[free_slot_r] <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr_r <= addr_r;
    if (accept) begin
      op_r         <= in_item.op;
      supported_r  <= (in_item.hw_type == arp_rc_pkg::HW_ETHERNET) &&
                      (in_item.proto_type == arp_rc_pkg::PROTO_IPV4);
      opc_r        <= in_item.arp_opcode;
      smac_r       <= in_item.sender_mac;
      sip_r        <= in_item.sender_ip;
      tip_r        <= in_item.target_ip;
      key_r        <= (in_item.op == arp_rc_pkg::OP_LOOKUP) ? in_item.target_ip
                                                            : in_item.sender_ip;
      addr_r       <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (rd_en) begin
        addr_r <= addr_r + AW'(1);
      end
      // Keep the lowest matching slot and the lowest free slot.
      if (cmp_hit && !found_r) begin
        found_r      <= 1'b1;
        match_slot_r <= cmp_addr_r;
        match_mac_r  <= rd_data.mac;
      end
      if (cmp_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= cmp_addr_r;
      end
    end
    if (commit) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

FILE: rtl/arp_receive_and_cache_core.sv
// Lookups and supported packets run ENG_SCAN, ENG_LAST, then ENG_COMMIT, which
// registers the result; an unsupported packet goes from ENG_IDLE to ENG_COMMIT.
// One request is handled at a time; a new one is taken only in ENG_IDLE.
// The scan reads the entry table linearly through its single read port, one
// entry per cycle; a stalled result holds the engine until taken.
// Reset: synchronous, active low; clears the entry valid bits at once, the config
// registers to zero and the output valid flag; no clearing pass is needed.
`default_nettype none

module arp_receive_and_cache_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [15:0] in_hw_type,
  input  wire logic [15:0] in_proto_type,
  input  wire logic [15:0] in_arp_opcode,
  input  wire logic [47:0] in_sender_mac,
  input  wire logic [31:0] in_sender_ip,
  input  wire logic [31:0] in_target_ip,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_merged,
  output logic             out_table_full,
  output logic             out_send_reply,
  output logic [47:0]      out_reply_dst_mac,
  output logic [31:0]      out_reply_dst_ip,
  output logic [47:0]      out_found_mac
);

  arp_rc_pkg::cfg_t    cfg;
  arp_rc_pkg::item_t   item;
  arp_rc_pkg::result_t res;

  arp_rc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.op         = in_op;
  assign item.hw_type    = in_hw_type;
  assign item.proto_type = in_proto_type;
  assign item.arp_opcode = in_arp_opcode;
  assign item.sender_mac = in_sender_mac;
  assign item.sender_ip  = in_sender_ip;
  assign item.target_ip  = in_target_ip;

  arp_rc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_status        = res.status;
  assign out_merged        = res.merged;
  assign out_table_full    = res.table_full;
  assign out_send_reply    = res.send_reply;
  assign out_reply_dst_mac = res.reply_dst_mac;
  assign out_reply_dst_ip  = res.reply_dst_ip;
  assign out_found_mac     = res.found_mac;

endmodule

`default_nettype wire

FILE: rtl/arp_rc_checker.sv
// Port-level checker for arp_receive_and_cache_core, bound to the top level.
// Depends on arp_rc_pkg for the status codes.
`default_nettype none

module arp_rc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic        out_merged,
  input wire logic        out_table_full,
  input wire logic        out_send_reply,
  input wire logic [47:0] out_found_mac
);

  // The engine works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");

  a_reply_iff_answered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_send_reply == (out_status == arp_rc_pkg::ST_ANSWERED)))
    else $error("send_reply disagrees with status");

  a_found_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != arp_rc_pkg::ST_HIT)) |-> (out_found_mac == 48'h0))
    else $error("found_mac nonzero without a hit");

  a_lookup_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == arp_rc_pkg::ST_HIT) ||
                   (out_status == arp_rc_pkg::ST_MISS) ||
                   (out_status == arp_rc_pkg::ST_DROPPED)))
    |-> (!out_merged && !out_table_full))
    else $error("table flags set on a lookup or dropped packet");

endmodule

bind arp_receive_and_cache_core arp_rc_checker u_arp_rc_checker (.*);

`default_nettype wire

FILE: tb/tb_arp_receive_and_cache_core.sv
// Testbench for arp_receive_and_cache_core: drives parsed ARP packets and lookups,
// predicts every result from a cache model of its own and checks it field by field.
// Depends on rtl/arp_rc_pkg.sv and rtl/arp_receive_and_cache_core.sv.
`default_nettype none

module tb_arp_receive_and_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_LOCAL_IP  = 0;
  localparam int REG_LOCAL_MAC = 1;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int POOL_SIZE     = 64;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [15:0] in_hw_type, in_proto_type, in_arp_opcode;
  logic [47:0] in_sender_mac;
  logic [31:0] in_sender_ip, in_target_ip;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_merged, out_table_full, out_send_reply;
  logic [47:0] out_reply_dst_mac;
  logic [31:0] out_reply_dst_ip;
  logic [47:0] out_found_mac;

  // Cache model and register copies.
  logic        cache_valid [arp_rc_pkg::ENTRIES];
  logic [31:0] cache_ip    [arp_rc_pkg::ENTRIES];
  logic [47:0] cache_mac   [arp_rc_pkg::ENTRIES];
  logic [31:0] cur_local_ip  = '0;
  logic [47:0] cur_local_mac = '0;

  arp_rc_pkg::result_t arp_results_due [$];
  arp_rc_pkg::result_t want;
  logic [31:0] ip_pool [POOL_SIZE];
  logic        idle_en = 1'b1;
  int          stall_left = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  arp_receive_and_cache_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_hw_type        (in_hw_type),
    .in_proto_type     (in_proto_type),
    .in_arp_opcode     (in_arp_opcode),
    .in_sender_mac     (in_sender_mac),
    .in_sender_ip      (in_sender_ip),
    .in_target_ip      (in_target_ip),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_merged        (out_merged),
    .out_table_full    (out_table_full),
    .out_send_reply    (out_send_reply),
    .out_reply_dst_mac (out_reply_dst_mac),
    .out_reply_dst_ip  (out_reply_dst_ip),
    .out_found_mac     (out_found_mac)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Cache prediction: the result of one request, with the cache updated as the block does.
  function automatic arp_rc_pkg::result_t resolve_arp(input arp_rc_pkg::item_t it);
    arp_rc_pkg::result_t r;
    int      slot;
    int      i;
    r = '0;
    slot = -1;
    if (it.op == arp_rc_pkg::OP_LOOKUP) begin
      for (i = 0; i < arp_rc_pkg::ENTRIES && slot < 0; i++)
        if (cache_valid[i] && cache_ip[i] == it.target_ip) slot = i;
      if (slot >= 0) begin
        r.status = arp_rc_pkg::ST_HIT;
        r.found_mac = cache_mac[slot];
      end else begin
        r.status = arp_rc_pkg::ST_MISS;
      end
    end else if (it.hw_type != arp_rc_pkg::HW_ETHERNET ||
                 it.proto_type != arp_rc_pkg::PROTO_IPV4) begin
      r.status = arp_rc_pkg::ST_DROPPED;
    end else begin
      for (i = 0; i < arp_rc_pkg::ENTRIES && slot < 0; i++)
        if (cache_valid[i] && cache_ip[i] == it.sender_ip) slot = i;
      if (slot >= 0) begin
        cache_mac[slot] = it.sender_mac;
        r.merged = 1'b1;
      end
      if (it.target_ip != cur_local_ip) begin
        r.status = arp_rc_pkg::ST_NOT_US;
      end else begin
        if (!r.merged) begin
          slot = -1;
          for (i = 0; i < arp_rc_pkg::ENTRIES && slot < 0; i++)
            if (!cache_valid[i]) slot = i;
          if (slot < 0) begin
            r.table_full = 1'b1;
          end else begin
            cache_valid[slot] = 1'b1;
            cache_ip[slot] = it.sender_ip;
            cache_mac[slot] = it.sender_mac;
          end
        end
        if (it.arp_opcode == arp_rc_pkg::OPC_REQUEST) begin
          r.status = arp_rc_pkg::ST_ANSWERED;
          r.send_reply = 1'b1;
          r.reply_dst_mac = it.sender_mac;
          r.reply_dst_ip = it.sender_ip;
        end else if (it.arp_opcode == arp_rc_pkg::OPC_REPLY) begin
          r.status = arp_rc_pkg::ST_LEARNED;
        end else begin
          r.status = arp_rc_pkg::ST_OTHER;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[47:0];
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_rc_pkg::item_t make_pkt(input logic [15:0] hw,
                                                 input logic [15:0] proto,
                                                 input logic [15:0] opc,
                                                 input logic [47:0] smac,
                                                 input logic [31:0] sip,
                                                 input logic [31:0] tip);
    arp_rc_pkg::item_t it;
    it.op = arp_rc_pkg::OP_PACKET;
    it.hw_type = hw;
    it.proto_type = proto;
    it.arp_opcode = opc;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.target_ip = tip;
    return it;
  endfunction

  // Header and sender fields are filled with noise; a lookup must ignore them.
  function automatic arp_rc_pkg::item_t make_lookup(input logic [31:0] tip);
    arp_rc_pkg::item_t it;
    it = make_pkt(16'($urandom), 16'($urandom), 16'($urandom), rand_mac(), $urandom, tip);
    it.op = arp_rc_pkg::OP_LOOKUP;
    return it;
  endfunction

  function automatic arp_rc_pkg::item_t random_arp_item();
    logic [15:0] hw, proto, opc;
    logic [31:0] tip;
    int          pick;
    if ($urandom_range(0, 99) < 25) return make_lookup(pick_ip());
    hw = ($urandom_range(0, 11) == 0) ? 16'($urandom) : arp_rc_pkg::HW_ETHERNET;
    proto = ($urandom_range(0, 11) == 0) ? 16'($urandom) : arp_rc_pkg::PROTO_IPV4;
    pick = $urandom_range(0, 9);
    if (pick < 4) opc = arp_rc_pkg::OPC_REQUEST;
    else if (pick < 8) opc = arp_rc_pkg::OPC_REPLY;
    else opc = 16'($urandom);
    tip = ($urandom_range(0, 9) < 6) ? cur_local_ip : pick_ip();
    return make_pkt(hw, proto, opc, rand_mac(), pick_ip(), tip);
  endfunction

  task automatic send_request(input arp_rc_pkg::item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= it.op;
    in_hw_type    <= it.hw_type;
    in_proto_type <= it.proto_type;
    in_arp_opcode <= it.arp_opcode;
    in_sender_mac <= it.sender_mac;
    in_sender_ip  <= it.sender_ip;
    in_target_ip  <= it.target_ip;
    do @(posedge clk); while (in_ready !== 1'b1);
    arp_results_due.push_back(resolve_arp(it));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (arp_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LOCAL_IP) cur_local_ip = value[31:0];
    else if (idx == REG_LOCAL_MAC) cur_local_mac = value[47:0];
  endtask

  // Registers change only with the block idle: every result back, then a short pause.
  task automatic configure(input logic [31:0] ip, input logic [47:0] mac);
    hold_until_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_LOCAL_IP, {32'd0, ip});
    write_reg(REG_LOCAL_MAC, {16'd0, mac});
  endtask

  task automatic test_directed();
    logic [31:0] ip_c, ip_d;
    ip_c = $urandom;
    ip_d = ip_c ^ 32'h0000_8000;
    configure($urandom, '1);
    send_request(make_lookup('0));
    send_request(make_pkt(16'h0000, arp_rc_pkg::PROTO_IPV4, arp_rc_pkg::OPC_REQUEST,
                          rand_mac(), ip_c, cur_local_ip));
    send_request(make_pkt(16'hFFFF, arp_rc_pkg::PROTO_IPV4, arp_rc_pkg::OPC_REQUEST,
                          rand_mac(), ip_c, cur_local_ip));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, 16'hFFFF, arp_rc_pkg::OPC_REPLY,
                          rand_mac(), ip_c, cur_local_ip));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, 16'h0000, arp_rc_pkg::OPC_REPLY,
                          rand_mac(), ip_c, cur_local_ip));
    // All-ones and all-zero senders get learned, then looked up.
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REQUEST, '1, '1, cur_local_ip));
    send_request(make_lookup('1));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REPLY, '0, '0, cur_local_ip));
    send_request(make_lookup('0));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4, 16'h0000,
                          rand_mac(), ip_c, cur_local_ip));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4, 16'hFFFF,
                          rand_mac(), '1, cur_local_ip));
    // Packets addressed elsewhere still refresh a known sender.
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REQUEST, rand_mac(), '1, ~cur_local_ip));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REQUEST, rand_mac(), ip_d, ~cur_local_ip));
    send_request(make_lookup(ip_d));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REQUEST, rand_mac(), '1, cur_local_ip));
    send_request(make_lookup('1));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REPLY, rand_mac(), '0, ip_c));
    send_request(make_lookup($urandom));
    send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                          arp_rc_pkg::OPC_REQUEST, rand_mac(), cur_local_ip,
                          cur_local_ip));
    send_request(make_lookup(cur_local_ip));
    send_request(make_lookup(ip_c));
  endtask

  task automatic test_random_traffic();
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    configure('0, rand_mac());
    repeat (500) send_request(random_arp_item());
    configure('1, '0);
    repeat (200) send_request(random_arp_item());
  endtask

  // Distinct senders addressed to us fill every slot, after which inserts report a full table.
  task automatic test_table_full();
    logic [31:0] fill_base;
    int          filled;
    fill_base = $urandom;
    filled = 0;
    configure($urandom, rand_mac());
    for (int k = 0; k < 330; k++) begin
      if (k == 165) hold_until_drained();
      if (k % 4 == 3) begin
        send_request(make_lookup(fill_base + $urandom_range(0, filled + 2)));
      end else begin
        send_request(make_pkt(arp_rc_pkg::HW_ETHERNET, arp_rc_pkg::PROTO_IPV4,
                              ($urandom_range(0, 1) != 0) ? arp_rc_pkg::OPC_REQUEST
                                                          : arp_rc_pkg::OPC_REPLY,
                              rand_mac(), fill_base + filled, cur_local_ip));
        filled++;
      end
    end
  endtask

  task automatic test_back_to_back();
    configure(ip_pool[0], rand_mac());
    idle_en <= 1'b0;
    repeat (150) send_request(random_arp_item());
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (arp_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request pending, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = arp_results_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("merged", 64'(want.merged), 64'(out_merged));
        check_field("table_full", 64'(want.table_full), 64'(out_table_full));
        check_field("send_reply", 64'(want.send_reply), 64'(out_send_reply));
        check_field("reply_dst_mac", 64'(want.reply_dst_mac), 64'(out_reply_dst_mac));
        check_field("reply_dst_ip", 64'(want.reply_dst_ip), 64'(out_reply_dst_ip));
        check_field("found_mac", 64'(want.found_mac), 64'(out_found_mac));
      end
    end
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (idle_en && $urandom_range(0, 19) == 0) stall_left = $urandom_range(1, 12);
    out_ready <= (stall_left == 0);
  end

  initial begin
    foreach (cache_valid[i]) cache_valid[i] = 1'b0;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_op         <= arp_rc_pkg::OP_PACKET;
    in_hw_type    <= '0;
    in_proto_type <= '0;
    in_arp_opcode <= '0;
    in_sender_mac <= '0;
    in_sender_ip  <= '0;
    in_target_ip  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_table_full();
    test_back_to_back();

    hold_until_drained();
    repeat (arp_rc_pkg::ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
